@@ hdl/weighted_round_robin_ring_core_macros.svh @@
// ---------------------------------------------------------------------------
// Weighted round-robin ring: assertion macros
// Immediate-implication and next-cycle property wrappers clocked on aclk.
// ---------------------------------------------------------------------------
`ifndef WEIGHTED_ROUND_ROBIN_RING_CORE_MACROS_SVH
`define WEIGHTED_ROUND_ROBIN_RING_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define WRRR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define WRRR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/wrrr_pkg.sv @@
// ---------------------------------------------------------------------------
// Weighted round-robin ring: shared package
// Sizes, codes and the structs passed between the controller and the cells.
// ---------------------------------------------------------------------------
package wrrr_pkg;

    // Ring geometry
    localparam int SLOTS   = 64;
    localparam int ID_BITS = 16;
    localparam int IDX_W   = $clog2(SLOTS);
    localparam int CNT_W   = $clog2(SLOTS + 1);
    localparam int HI_W    = CNT_W + 1;
    localparam int THR_W   = 10;

    typedef logic [ID_BITS-1:0] id_t;
    typedef logic [IDX_W-1:0]   idx_t;
    typedef logic [CNT_W-1:0]   cnt_t;
    typedef logic [HI_W-1:0]    hi_t;
    typedef logic [THR_W-1:0]   thr_t;

    // Item modes
    localparam logic [2:0] MODE_ADD     = 3'd0;
    localparam logic [2:0] MODE_REMOVE  = 3'd1;
    localparam logic [2:0] MODE_NEXT    = 3'd2;
    localparam logic [2:0] MODE_EXISTS  = 3'd3;
    localparam logic [2:0] MODE_CURRENT = 3'd4;

    // Result status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_EMPTY    = 3'd1;
    localparam logic [2:0] ST_BELOW    = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] CFG_CRITICAL = 2'd0;
    localparam logic [1:0] CFG_DOUBLE   = 2'd1;
    localparam logic [1:0] CFG_TRIPLE   = 2'd2;

    // Threshold reset values
    localparam thr_t CRIT_RST   = 10'd600;
    localparam thr_t DOUBLE_RST = 10'd760;
    localparam thr_t TRIPLE_RST = 10'd900;

    // Cell operations
    localparam logic [1:0] OP_HOLD = 2'd0;
    localparam logic [1:0] OP_ADD  = 2'd1;
    localparam logic [1:0] OP_MARK = 2'd2;
    localparam logic [1:0] OP_SWAP = 2'd3;

    // Broadcast control to every cell
    typedef struct packed {
        logic [1:0] op;
        id_t        cmd_id;
        logic       phase;
        cnt_t       used;
        hi_t        add_hi;
        idx_t       cursor;
    } cell_ctrl_t;

    // What a cell shows its neighbors
    typedef struct packed {
        id_t  id;
        logic dead;
        logic tag;
        logic live;
    } cell_link_t;

endpackage

@@ hdl/wrrr_cell.sv @@
// ---------------------------------------------------------------------------
// Weighted round-robin ring: slot cell
// Holds one identifier with its remove mark and cursor tag, and swaps with a
// neighbor during compaction (odd-even transposition of dead and live slots).
// ---------------------------------------------------------------------------
module wrrr_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  wrrr_pkg::idx_t      idx_i,
    input  wrrr_pkg::cell_ctrl_t ctrl_i,
    input  wrrr_pkg::cell_link_t left_i,
    input  wrrr_pkg::cell_link_t right_i,
    output wrrr_pkg::cell_link_t link_o,
    output logic                pend_o,
    output logic                bound_o,
    output logic                match_o,
    output wrrr_pkg::id_t       rd_id_o
);

    wrrr_pkg::id_t id_reg, id_next;
    logic          dead_reg, dead_next;
    logic          tag_reg, tag_next;
    logic          occ;
    logic          live;
    logic          add_hit;
    logic          left_of_pair;
    logic          swap_as_left;
    logic          swap_as_right;

    // Occupancy and per-cell decodes
    assign occ     = wrrr_pkg::cnt_t'(idx_i) < ctrl_i.used;
    assign live    = occ & ~dead_reg;
    assign add_hit = (wrrr_pkg::hi_t'(idx_i) >= wrrr_pkg::hi_t'(ctrl_i.used)) &&
                     (wrrr_pkg::hi_t'(idx_i) < ctrl_i.add_hi);
    assign match_o = occ && (id_reg == ctrl_i.cmd_id);

    // Pairing for this phase: left member when the index parity matches
    assign left_of_pair  = (idx_i[0] == ctrl_i.phase);
    assign swap_as_left  = left_of_pair & dead_reg & right_i.live;
    assign swap_as_right = ~left_of_pair & left_i.dead & live;

    // Neighbor-facing status
    assign link_o  = '{id: id_reg, dead: dead_reg, tag: tag_reg, live: live};
    assign pend_o  = dead_reg & right_i.live;
    assign bound_o = live & ~right_i.live;
    assign rd_id_o = (idx_i == ctrl_i.cursor) ? id_reg : '0;

    // Next state
    always_comb begin
        id_next   = id_reg;
        dead_next = dead_reg;
        tag_next  = tag_reg;
        case (ctrl_i.op)
            wrrr_pkg::OP_ADD: begin
                if (add_hit) begin
                    id_next = ctrl_i.cmd_id;
                end
            end
            wrrr_pkg::OP_MARK: begin
                dead_next = match_o;
                tag_next  = (idx_i == ctrl_i.cursor);
            end
            wrrr_pkg::OP_SWAP: begin
                // dead slot moves right; a cursor tag on it passes to the live slot
                if (swap_as_left) begin
                    id_next   = right_i.id;
                    dead_next = 1'b0;
                    tag_next  = tag_reg | right_i.tag;
                end else if (swap_as_right) begin
                    id_next   = left_i.id;
                    dead_next = 1'b1;
                    tag_next  = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    // Control bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dead_reg <= 1'b0;
            tag_reg  <= 1'b0;
        end else begin
            dead_reg <= dead_next;
            tag_reg  <= tag_next;
        end
    end

    // Stored identifier
    always_ff @(posedge aclk) begin
        id_reg <= id_next;
    end

endmodule

@@ hdl/wrrr_enc.sv @@
// ---------------------------------------------------------------------------
// Weighted round-robin ring: one-hot encoder
// Turns a one-hot row of cell flags into a slot index.
// ---------------------------------------------------------------------------
module wrrr_enc (
    input  logic [wrrr_pkg::SLOTS-1:0] hot_i,
    output wrrr_pkg::idx_t             idx_o,
    output logic                       any_o
);

    // OR of the indexes of set bits
    always_comb begin
        idx_o = '0;
        for (int i = 0; i < wrrr_pkg::SLOTS; i++) begin
            if (hot_i[i]) begin
                idx_o = idx_o | wrrr_pkg::idx_t'(i);
            end
        end
    end

    assign any_o = |hot_i;

endmodule

@@ hdl/weighted_round_robin_ring_core.sv @@
// ---------------------------------------------------------------------------
// Weighted round-robin ring core
// One item at a time: add, remove, next, exists and current items each give
// one result. Add, next, exists, current and unused modes go from acceptance
// through the execute and done states to result valid. The input reopens as
// the result goes out, so no new item is taken until the last result is out.
// A remove marks matching slots in the execute state, then compacts the chain
// of slot cells by swapping dead and live neighbors, alternating even and odd
// pairs, one step a cycle, and then passes to the done state. A result still
// waiting in the output register holds the next result, and with it the
// input, until it is taken. Thresholds may be written at any time the core is
// idle; cfg_ready is always high and writes to index 3 are ignored.
// ---------------------------------------------------------------------------
`include "weighted_round_robin_ring_core_macros.svh"

module weighted_round_robin_ring_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    // input items
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [2:0]           s_mode,
    input  wrrr_pkg::id_t        s_entry_id,
    input  wrrr_pkg::thr_t       s_risk_permille,
    // result items
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [2:0]           m_status,
    output wrrr_pkg::id_t        m_result_id,
    output wrrr_pkg::cnt_t       m_slot_count,
    output wrrr_pkg::cnt_t       m_occupancy,
    output logic                 m_found,
    // threshold writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_index,
    input  wrrr_pkg::thr_t       cfg_data
);

    localparam logic [1:0] S_IDLE    = 2'd0;
    localparam logic [1:0] S_EXEC    = 2'd1;
    localparam logic [1:0] S_COMPACT = 2'd2;
    localparam logic [1:0] S_DONE    = 2'd3;

    localparam wrrr_pkg::cnt_t RING_SIZE = wrrr_pkg::cnt_t'(wrrr_pkg::SLOTS);

    logic [1:0]            state_reg, state_next;
    logic [2:0]            cmd_mode_reg, cmd_mode_next;
    wrrr_pkg::id_t         cmd_id_reg, cmd_id_next;
    wrrr_pkg::thr_t        cmd_risk_reg, cmd_risk_next;
    wrrr_pkg::thr_t        crit_reg, crit_next;
    wrrr_pkg::thr_t        dbl_reg, dbl_next;
    wrrr_pkg::thr_t        tri_reg, tri_next;
    wrrr_pkg::cnt_t        used_reg, used_next;
    wrrr_pkg::idx_t        cursor_reg, cursor_next;
    logic                  phase_reg, phase_next;
    logic [2:0]            res_status_reg, res_status_next;
    wrrr_pkg::cnt_t        res_count_reg, res_count_next;
    logic                  res_found_reg, res_found_next;
    logic                  res_rd_reg, res_rd_next;
    logic                  m_valid_reg, m_valid_next;
    logic [2:0]            m_status_reg, m_status_next;
    wrrr_pkg::id_t         m_result_id_reg, m_result_id_next;
    wrrr_pkg::cnt_t        m_slot_count_reg, m_slot_count_next;
    wrrr_pkg::cnt_t        m_occupancy_reg, m_occupancy_next;
    logic                  m_found_reg, m_found_next;

    logic [1:0]            cell_op;
    wrrr_pkg::cell_ctrl_t  cell_ctrl;
    wrrr_pkg::cell_link_t  link [wrrr_pkg::SLOTS];
    logic [wrrr_pkg::SLOTS-1:0] pend_vec;
    logic [wrrr_pkg::SLOTS-1:0] bound_vec;
    logic [wrrr_pkg::SLOTS-1:0] match_vec;
    logic [wrrr_pkg::SLOTS-1:0] tag_live_vec;
    logic [wrrr_pkg::SLOTS-1:0] tag_vec;
    wrrr_pkg::id_t         rd_id [wrrr_pkg::SLOTS];
    wrrr_pkg::id_t         cursor_id;

    logic [1:0]            weight;
    wrrr_pkg::hi_t         add_sum;
    logic                  below;
    logic                  full;
    wrrr_pkg::cnt_t        cur_inc;
    wrrr_pkg::idx_t        cursor_wrap;
    wrrr_pkg::idx_t        bound_idx;
    logic                  bound_any;
    wrrr_pkg::idx_t        tag_idx;
    logic                  tag_any;
    wrrr_pkg::cnt_t        kept;
    wrrr_pkg::cnt_t        removed;
    logic                  any_pend;
    logic                  any_match;
    logic                  out_free;
    logic                  compact_step;

    // Handshake outputs
    assign s_ready      = (state_reg == S_IDLE);
    assign cfg_ready    = 1'b1;
    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_result_id  = m_result_id_reg;
    assign m_slot_count = m_slot_count_reg;
    assign m_occupancy  = m_occupancy_reg;
    assign m_found      = m_found_reg;
    assign out_free     = ~m_valid_reg | m_ready;

    // Broadcast control
    assign cell_ctrl = '{op: cell_op, cmd_id: cmd_id_reg, phase: phase_reg,
                         used: used_reg, add_hi: add_sum, cursor: cursor_reg};

    // Chain of slot cells
    for (genvar g = 0; g < wrrr_pkg::SLOTS; g++) begin : g_cell
        wrrr_pkg::cell_link_t left_link;
        wrrr_pkg::cell_link_t right_link;
        if (g == 0) begin : g_head
            assign left_link = '0;
        end else begin : g_mid_l
            assign left_link = link[g-1];
        end
        if (g == wrrr_pkg::SLOTS - 1) begin : g_tail
            assign right_link = '0;
        end else begin : g_mid_r
            assign right_link = link[g+1];
        end
        wrrr_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .idx_i   (wrrr_pkg::idx_t'(g)),
            .ctrl_i  (cell_ctrl),
            .left_i  (left_link),
            .right_i (right_link),
            .link_o  (link[g]),
            .pend_o  (pend_vec[g]),
            .bound_o (bound_vec[g]),
            .match_o (match_vec[g]),
            .rd_id_o (rd_id[g])
        );
        assign tag_vec[g]      = link[g].tag;
        assign tag_live_vec[g] = link[g].tag & link[g].live;
    end

    // Identifier at the cursor
    always_comb begin
        cursor_id = '0;
        for (int i = 0; i < wrrr_pkg::SLOTS; i++) begin
            cursor_id = cursor_id | rd_id[i];
        end
    end

    assign any_pend  = |pend_vec;
    assign any_match = |match_vec;

    // End of the live run gives the kept count
    wrrr_enc u_bound_enc (
        .hot_i (bound_vec),
        .idx_o (bound_idx),
        .any_o (bound_any)
    );

    // Surviving slot that carries the cursor tag
    wrrr_enc u_tag_enc (
        .hot_i (tag_live_vec),
        .idx_o (tag_idx),
        .any_o (tag_any)
    );

    assign kept    = bound_any ? (wrrr_pkg::cnt_t'(bound_idx) + 1'b1) : '0;
    assign removed = used_reg - kept;

    // Add weight and fit check (triple test first)
    assign below   = cmd_risk_reg < crit_reg;
    assign weight  = (cmd_risk_reg >= tri_reg) ? 2'd3 :
                     (cmd_risk_reg >= dbl_reg) ? 2'd2 : 2'd1;
    assign add_sum = wrrr_pkg::hi_t'(used_reg) + wrrr_pkg::hi_t'(weight);
    assign full    = add_sum > wrrr_pkg::hi_t'(wrrr_pkg::SLOTS);

    // Cursor advance with wrap
    assign cur_inc     = wrrr_pkg::cnt_t'(cursor_reg) + 1'b1;
    assign cursor_wrap = (cur_inc == used_reg) ? '0 : cur_inc[wrrr_pkg::IDX_W-1:0];

    // Sequencer and next-state logic
    always_comb begin
        state_next        = state_reg;
        cmd_mode_next     = cmd_mode_reg;
        cmd_id_next       = cmd_id_reg;
        cmd_risk_next     = cmd_risk_reg;
        crit_next         = crit_reg;
        dbl_next          = dbl_reg;
        tri_next          = tri_reg;
        used_next         = used_reg;
        cursor_next       = cursor_reg;
        phase_next        = phase_reg;
        res_status_next   = res_status_reg;
        res_count_next    = res_count_reg;
        res_found_next    = res_found_reg;
        res_rd_next       = res_rd_reg;
        m_valid_next      = m_valid_reg & ~m_ready;
        m_status_next     = m_status_reg;
        m_result_id_next  = m_result_id_reg;
        m_slot_count_next = m_slot_count_reg;
        m_occupancy_next  = m_occupancy_reg;
        m_found_next      = m_found_reg;
        cell_op           = wrrr_pkg::OP_HOLD;

        // threshold writes
        if (cfg_valid) begin
            case (cfg_index)
                wrrr_pkg::CFG_CRITICAL: crit_next = cfg_data;
                wrrr_pkg::CFG_DOUBLE:   dbl_next  = cfg_data;
                wrrr_pkg::CFG_TRIPLE:   tri_next  = cfg_data;
                default: begin
                end
            endcase
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd_mode_next = s_mode;
                    cmd_id_next   = s_entry_id;
                    cmd_risk_next = s_risk_permille;
                    state_next    = S_EXEC;
                end
            end
            S_EXEC: begin
                res_status_next = wrrr_pkg::ST_OK;
                res_count_next  = '0;
                res_found_next  = 1'b0;
                res_rd_next     = 1'b0;
                phase_next      = 1'b0;
                case (cmd_mode_reg)
                    wrrr_pkg::MODE_ADD: begin
                        if (below) begin
                            res_status_next = wrrr_pkg::ST_BELOW;
                        end else if (full) begin
                            res_status_next = wrrr_pkg::ST_FULL;
                        end else begin
                            cell_op        = wrrr_pkg::OP_ADD;
                            used_next      = add_sum[wrrr_pkg::CNT_W-1:0];
                            res_count_next = wrrr_pkg::cnt_t'(weight);
                            if (used_reg == '0) begin
                                cursor_next = '0;
                            end
                        end
                    end
                    wrrr_pkg::MODE_REMOVE: begin
                        cell_op = wrrr_pkg::OP_MARK;
                    end
                    wrrr_pkg::MODE_NEXT: begin
                        if (used_reg == '0) begin
                            res_status_next = wrrr_pkg::ST_EMPTY;
                        end else begin
                            cursor_next = cursor_wrap;
                            res_rd_next = 1'b1;
                        end
                    end
                    wrrr_pkg::MODE_EXISTS: begin
                        res_found_next = any_match;
                    end
                    wrrr_pkg::MODE_CURRENT: begin
                        if (used_reg == '0) begin
                            res_status_next = wrrr_pkg::ST_EMPTY;
                        end else begin
                            res_rd_next = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
                state_next = (cmd_mode_reg == wrrr_pkg::MODE_REMOVE) ? S_COMPACT : S_DONE;
            end
            S_COMPACT: begin
                if (any_pend) begin
                    cell_op    = wrrr_pkg::OP_SWAP;
                    phase_next = ~phase_reg;
                end else begin
                    // chain settled: live slots first, dead ones after
                    res_count_next = removed;
                    if (removed == '0) begin
                        res_status_next = wrrr_pkg::ST_NOTFOUND;
                    end else begin
                        used_next   = kept;
                        cursor_next = tag_any ? tag_idx : '0;
                    end
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    m_valid_next      = 1'b1;
                    m_status_next     = res_status_reg;
                    m_result_id_next  = res_rd_reg ? cursor_id : '0;
                    m_slot_count_next = res_count_reg;
                    m_occupancy_next  = used_reg;
                    m_found_next      = res_found_reg;
                    state_next        = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            used_reg    <= '0;
            cursor_reg  <= '0;
            phase_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
            crit_reg    <= wrrr_pkg::CRIT_RST;
            dbl_reg     <= wrrr_pkg::DOUBLE_RST;
            tri_reg     <= wrrr_pkg::TRIPLE_RST;
        end else begin
            state_reg   <= state_next;
            used_reg    <= used_next;
            cursor_reg  <= cursor_next;
            phase_reg   <= phase_next;
            m_valid_reg <= m_valid_next;
            crit_reg    <= crit_next;
            dbl_reg     <= dbl_next;
            tri_reg     <= tri_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        cmd_mode_reg     <= cmd_mode_next;
        cmd_id_reg       <= cmd_id_next;
        cmd_risk_reg     <= cmd_risk_next;
        res_status_reg   <= res_status_next;
        res_count_reg    <= res_count_next;
        res_found_reg    <= res_found_next;
        res_rd_reg       <= res_rd_next;
        m_status_reg     <= m_status_next;
        m_result_id_reg  <= m_result_id_next;
        m_slot_count_reg <= m_slot_count_next;
        m_occupancy_reg  <= m_occupancy_next;
        m_found_reg      <= m_found_next;
    end

    // Checks
    assign compact_step = (state_reg == S_COMPACT) & any_pend;

    `WRRR_ASSERT_NOW(a_used_bound, 1'b1, used_reg <= RING_SIZE, "occupancy above ring size")
    `WRRR_ASSERT_NOW(a_cursor_in_ring, used_reg != '0, cur_inc <= used_reg, "cursor past tail")
    `WRRR_ASSERT_NOW(a_tag_onehot, state_reg == S_COMPACT, $onehot(tag_vec), "tag not one-hot")
    `WRRR_ASSERT_NEXT(a_compact_used_stable, compact_step, $stable(used_reg), "used changed")

endmodule
